/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BBVN_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define BBVN_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hdl/bbvn_pkg.sv */
// ----------------------------------------------------------------------------
// bbvn_pkg
// Shared types and constants of the bounding box vertex normalizer.
// ----------------------------------------------------------------------------
package bbvn_pkg;

	localparam int unsigned MaxVerticesDefault = 64;
	localparam int unsigned SideW = 31;
	localparam int unsigned DivSteps = 32;
	localparam logic [SideW-1:0] SideReset = 31'd131072;

	typedef logic signed [31:0] coord_t;
	typedef logic [31:0] mag_t;

	// One vertex handed from the front to the back: offsets from the minimum,
	// axis ranges, flat flags and the end-of-run mark.
	typedef struct packed {
		mag_t [2:0] delta;
		mag_t [2:0] range;
		logic [2:0] flat;
		logic       last;
	} job_t;

	typedef enum logic [1:0] {FR_LOAD, FR_READ, FR_PUSH} front_state_t;
	typedef enum logic [2:0] {BK_IDLE, BK_MUL, BK_ADD, BK_DIV, BK_DONE} back_state_t;

endpackage

/* hdl/bounding_box_vertex_normalizer_core.sv */
// ----------------------------------------------------------------------------
// bounding_box_vertex_normalizer_core
// Per-axis min/max normalizer for a mesh of signed Q16.16 vertices.
// ----------------------------------------------------------------------------
// Vertices enter one beat per cycle and are stored (up to MAX_VERTICES; extra
// vertices are dropped) while the minimum and maximum of each axis are
// tracked. The beat marked final_vertex starts the output pass: every stored
// vertex leaves in arrival order, each axis mapped on its own to
// round((v - min) * side_length / (max - min)) - floor(side_length / 2), so the
// axes are not scaled equally. An axis with zero range gives 0 and sets its
// flat_axis bit; end_of_run marks the last result. During the output pass no
// input beat is taken. The front reads each stored vertex (FR_READ) and
// pushes it (FR_PUSH) into a two-entry queue; the back takes one vertex at a
// time through multiply, round, a 32-step radix-2 divider per axis (one bit
// per cycle) and the output register. The divider sets the pace of the pass.
// The user must write side_length through cfg_we/cfg_wdata only while the
// block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module bounding_box_vertex_normalizer_core #(
	parameter int unsigned MAX_VERTICES = bbvn_pkg::MaxVerticesDefault
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bbvn_pkg::SideW-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  bbvn_pkg::coord_t           coord_x,
	input  bbvn_pkg::coord_t           coord_y,
	input  bbvn_pkg::coord_t           coord_z,
	input  logic                       final_vertex,
	output logic                       out_valid,
	input  logic                       out_ready,
	output bbvn_pkg::coord_t           norm_x,
	output bbvn_pkg::coord_t           norm_y,
	output bbvn_pkg::coord_t           norm_z,
	output logic [2:0]                 flat_axis,
	output logic                       end_of_run
);
	import bbvn_pkg::*;

	// Target side length, unsigned Q15.16.
	logic [SideW-1:0] side_q;

	// Jobs from the front into the queue, and from the queue into the back.
	logic fq_valid, fq_ready, bq_valid, bq_ready;
	job_t fq_data, bq_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SideReset;
		end else if (cfg_we) begin
			side_q <= cfg_wdata;
		end
	end

	// The front stores vertices and replays them with the bounds applied.
	bbvn_front #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.coord_z     (coord_z),
		.final_vertex(final_vertex),
		.job_valid   (fq_valid),
		.job_ready   (fq_ready),
		.job         (fq_data)
	);

	// The queue lets the front fetch the next vertex while the back divides.
	bbvn_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(fq_valid),
		.wr_ready(fq_ready),
		.wr_data (fq_data),
		.rd_valid(bq_valid),
		.rd_ready(bq_ready),
		.rd_data (bq_data)
	);

	// The back does the arithmetic and owns the output register.
	bbvn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (bq_valid),
		.job_ready (bq_ready),
		.job       (bq_data),
		.side      (side_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.norm_x    (norm_x),
		.norm_y    (norm_y),
		.norm_z    (norm_z),
		.flat_axis (flat_axis),
		.end_of_run(end_of_run)
	);

endmodule

/* hdl/bbvn_front.sv */
// ----------------------------------------------------------------------------
// bbvn_front
// Stores incoming vertices, tracks per-axis bounds and replays the run.
// ----------------------------------------------------------------------------
module bbvn_front #(
	parameter int unsigned MAX_VERTICES = bbvn_pkg::MaxVerticesDefault
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  bbvn_pkg::coord_t coord_x,
	input  bbvn_pkg::coord_t coord_y,
	input  bbvn_pkg::coord_t coord_z,
	input  logic             final_vertex,
	output logic             job_valid,
	input  logic             job_ready,
	output bbvn_pkg::job_t   job
);
	import bbvn_pkg::*;
	`include "assert_macros.svh"

	localparam int unsigned IdxW = $clog2(MAX_VERTICES);
	localparam int unsigned CntW = $clog2(MAX_VERTICES + 1);
	localparam logic [CntW-1:0] CntMax = CntW'(MAX_VERTICES);

	front_state_t state_q, state_d;
	logic [CntW-1:0] count_q, count_d;
	logic [IdxW-1:0] rd_idx_q, rd_idx_d, last_idx_q, last_idx_d;
	coord_t min_q [3];
	coord_t max_q [3];
	coord_t vin [3];
	logic [95:0] mem [MAX_VERTICES];
	logic [95:0] rdata_q;
	logic accept, store;

	assign vin[0] = coord_x;
	assign vin[1] = coord_y;
	assign vin[2] = coord_z;
	assign in_ready = (state_q == FR_LOAD);
	assign accept = in_valid && in_ready;
	assign store = accept && (count_q < CntMax);

	always_ff @(posedge clk) begin
		if (store) begin
			mem[count_q[IdxW-1:0]] <= {coord_z, coord_y, coord_x};
		end
		rdata_q <= mem[rd_idx_q];
	end

	// The first vertex of a run loads the bounds outright.
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			if (store && (count_q == '0 || vin[a] < min_q[a])) begin
				min_q[a] <= vin[a];
			end
			if (store && (count_q == '0 || vin[a] > max_q[a])) begin
				max_q[a] <= vin[a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_LOAD;
			count_q <= '0;
			rd_idx_q <= '0;
			last_idx_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rd_idx_q <= rd_idx_d;
			last_idx_q <= last_idx_d;
		end
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		rd_idx_d = rd_idx_q;
		last_idx_d = last_idx_q;
		job_valid = 1'b0;
		unique case (state_q)
			FR_LOAD: begin
				if (store) begin
					count_d = count_q + 1'b1;
				end
				if (accept && final_vertex) begin
					state_d = FR_READ;
					rd_idx_d = '0;
					last_idx_d = store ? count_q[IdxW-1:0] : IdxW'(MAX_VERTICES - 1);
				end
			end
			FR_READ: begin
				state_d = FR_PUSH;
			end
			FR_PUSH: begin
				job_valid = 1'b1;
				if (job_ready) begin
					if (rd_idx_q == last_idx_q) begin
						count_d = '0;
						state_d = FR_LOAD;
					end else begin
						rd_idx_d = rd_idx_q + 1'b1;
						state_d = FR_READ;
					end
				end
			end
			default: state_d = FR_LOAD;
		endcase
	end

	always_comb begin
		logic [32:0] d_ext, r_ext;
		coord_t v;
		for (int a = 0; a < 3; a++) begin
			v = rdata_q[a*32 +: 32];
			d_ext = {v[31], v} - {min_q[a][31], min_q[a]};
			r_ext = {max_q[a][31], max_q[a]} - {min_q[a][31], min_q[a]};
			job.delta[a] = d_ext[31:0];
			job.range[a] = r_ext[31:0];
			job.flat[a] = (r_ext[31:0] == '0);
		end
		job.last = (rd_idx_q == last_idx_q);
	end

	`BBVN_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntMax)
	`BBVN_ASSERT_NOW(a_last_stored, state_q != FR_LOAD, CntW'(last_idx_q) < count_q)
	`BBVN_ASSERT_NEXT(a_run_clears, job_valid && job_ready && job.last,
		count_q == '0 && state_q == FR_LOAD)

endmodule

/* hdl/bbvn_fifo.sv */
// ----------------------------------------------------------------------------
// bbvn_fifo
// Two-entry queue of vertex jobs between the front and the back.
// ----------------------------------------------------------------------------
module bbvn_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  bbvn_pkg::job_t wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output bbvn_pkg::job_t rd_data
);
	import bbvn_pkg::*;

	job_t entry_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;
	logic push, pop;

	assign wr_ready = (fill_q != 2'd2);
	assign rd_valid = (fill_q != 2'd0);
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

/* hdl/bbvn_back.sv */
// ----------------------------------------------------------------------------
// bbvn_back
// Scales one vertex per job: multiply, round, divide by the axis range.
// ----------------------------------------------------------------------------
module bbvn_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       job_valid,
	output logic                       job_ready,
	input  bbvn_pkg::job_t             job,
	input  logic [bbvn_pkg::SideW-1:0] side,
	output logic                       out_valid,
	input  logic                       out_ready,
	output bbvn_pkg::coord_t           norm_x,
	output bbvn_pkg::coord_t           norm_y,
	output bbvn_pkg::coord_t           norm_z,
	output logic [2:0]                 flat_axis,
	output logic                       end_of_run
);
	import bbvn_pkg::*;

	localparam int unsigned StepW = $clog2(DivSteps);

	back_state_t state_q, state_d;
	logic [StepW-1:0] step_q;
	logic out_valid_q;
	job_t job_q;
	logic [62:0] prod_q [3];
	mag_t rem_q [3];
	mag_t low_q [3];
	coord_t res [3];
	logic take, load_out;

	assign job_ready = (state_q == BK_IDLE);
	assign take = job_valid && job_ready;
	assign load_out = (state_q == BK_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (take) state_d = BK_MUL;
			BK_MUL:  state_d = BK_ADD;
			BK_ADD:  state_d = BK_DIV;
			BK_DIV:  if (step_q == StepW'(DivSteps - 1)) state_d = BK_DONE;
			BK_DONE: if (load_out) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_DIV) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Restoring division: the high word of the numerator is already below
	// the range, so 32 steps yield the whole quotient in low_q.
	always_ff @(posedge clk) begin
		logic [32:0] t, diff;
		logic [63:0] num;
		if (take) begin
			job_q <= job;
		end
		for (int a = 0; a < 3; a++) begin
			unique case (state_q)
				BK_MUL: prod_q[a] <= job_q.delta[a] * side;
				BK_ADD: begin
					num = {1'b0, prod_q[a]} + {33'd0, job_q.range[a][31:1]};
					rem_q[a] <= num[63:32];
					low_q[a] <= num[31:0];
				end
				BK_DIV: begin
					t = {rem_q[a], low_q[a][31]};
					diff = t - {1'b0, job_q.range[a]};
					if (t >= {1'b0, job_q.range[a]}) begin
						rem_q[a] <= diff[31:0];
						low_q[a] <= {low_q[a][30:0], 1'b1};
					end else begin
						rem_q[a] <= t[31:0];
						low_q[a] <= {low_q[a][30:0], 1'b0};
					end
				end
				default: ;
			endcase
		end
		if (load_out) begin
			norm_x <= res[0];
			norm_y <= res[1];
			norm_z <= res[2];
			flat_axis <= job_q.flat;
			end_of_run <= job_q.last;
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			res[a] = job_q.flat[a] ? '0 : coord_t'(low_q[a] - {2'b0, side[SideW-1:1]});
		end
	end

endmodule

/* tb/sv/bounding_box_vertex_normalizer_core_test.sv */
// ----------------------------------------------------------------------------
// bounding_box_vertex_normalizer_core_test
// Self-checking regression of the per-axis vertex normalizer.
// ----------------------------------------------------------------------------
// Meshes of random and directed vertices are streamed into the block. A
// software copy of the store and of the axis bounds predicts every normalized
// vertex, and a checker compares each output beat field by field. The run
// covers several side lengths, flat axes, store overflow and random idling
// on both channels.
// ----------------------------------------------------------------------------
module bounding_box_vertex_normalizer_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import bbvn_pkg::*;

	localparam int unsigned Depth = MaxVerticesDefault;
	localparam int unsigned WatchLimit = 20000;

	typedef struct packed {
		coord_t     x;
		coord_t     y;
		coord_t     z;
		logic [2:0] flat;
		logic       last;
	} norm_beat_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [SideW-1:0] cfg_wdata = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	coord_t           coord_x = '0;
	coord_t           coord_y = '0;
	coord_t           coord_z = '0;
	logic             final_vertex = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	coord_t           norm_x;
	coord_t           norm_y;
	coord_t           norm_z;
	logic [2:0]       flat_axis;
	logic             end_of_run;

	// Predictor state: the mirror of the block's store and bounds.
	coord_t           mesh_store [Depth][3];
	int unsigned      mesh_count = 0;
	coord_t           axis_lo [3];
	coord_t           axis_hi [3];
	logic [SideW-1:0] side_now = SideReset;

	norm_beat_t       pending_norms [$];
	int unsigned      error_count = 0;
	int unsigned      send_idle_pct = 0;
	int unsigned      recv_stall_pct = 0;
	bit               hold_receiver = 1'b0;
	int unsigned      quiet_cycles = 0;

	always #6 clk = ~clk;

	bounding_box_vertex_normalizer_core u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.final_vertex(final_vertex),
		.out_valid(out_valid), .out_ready(out_ready),
		.norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
		.flat_axis(flat_axis), .end_of_run(end_of_run)
	);

	// Rounded map of one axis value into [-side/2, side/2]. The differences
	// are taken at 64 bits so a full 32-bit span does not wrap.
	function automatic coord_t scale_axis(coord_t v, coord_t lo, coord_t hi,
			logic [SideW-1:0] s);
		logic [63:0] span;
		logic [63:0] offs;
		logic [63:0] quot;
		span = 64'(longint'(hi) - longint'(lo));
		offs = 64'(longint'(v) - longint'(lo));
		quot = (offs * 64'(s) + (span >> 1)) / span;
		return coord_t'(quot - 64'(s >> 1));
	endfunction

	// Updates the mirror with one accepted vertex and, on the final one,
	// queues every normalized vertex of the mesh.
	task automatic predict_vertex(coord_t vx, coord_t vy, coord_t vz, logic fin);
		coord_t     c [3];
		logic [2:0] flat;
		norm_beat_t nb;
		c[0] = vx;
		c[1] = vy;
		c[2] = vz;
		if (mesh_count < Depth) begin
			for (int a = 0; a < 3; a++) begin
				mesh_store[mesh_count][a] = c[a];
				if (mesh_count == 0 || c[a] < axis_lo[a]) axis_lo[a] = c[a];
				if (mesh_count == 0 || c[a] > axis_hi[a]) axis_hi[a] = c[a];
			end
			mesh_count++;
		end
		if (!fin) return;
		for (int a = 0; a < 3; a++)
			flat[a] = (axis_lo[a] == axis_hi[a]);
		for (int i = 0; i < mesh_count; i++) begin
			nb.x = flat[0] ? '0 : scale_axis(mesh_store[i][0], axis_lo[0], axis_hi[0], side_now);
			nb.y = flat[1] ? '0 : scale_axis(mesh_store[i][1], axis_lo[1], axis_hi[1], side_now);
			nb.z = flat[2] ? '0 : scale_axis(mesh_store[i][2], axis_lo[2], axis_hi[2], side_now);
			nb.flat = flat;
			nb.last = (i + 1 == mesh_count);
			pending_norms.push_back(nb);
		end
		mesh_count = 0;
	endtask

	// Sends one vertex beat, with a random idle gap before it. Valid stays
	// high across back-to-back beats; it drops when a gap is taken or the sender pauses.
	task automatic send_vertex(coord_t vx, coord_t vy, coord_t vz, logic fin);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid     <= 1'b1;
		coord_x      <= vx;
		coord_y      <= vy;
		coord_z      <= vz;
		final_vertex <= fin;
		do @(posedge clk); while (!in_ready);
		predict_vertex(vx, vy, vz, fin);
	endtask

	task automatic pause_sender();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every queued result has come out, then lets the back end
	// settle before the register may be touched.
	task automatic drain_outputs();
		pause_sender();
		while (pending_norms.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_side(logic [SideW-1:0] s);
		cfg_we    <= 1'b1;
		cfg_wdata <= s;
		@(posedge clk);
		cfg_we    <= 1'b0;
		side_now  = s;
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(5))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return coord_t'($signed(16'($urandom)));
			default: return coord_t'($urandom);
		endcase
	endfunction

	// Sends one mesh of n vertices; the last one carries the final mark.
	task automatic send_mesh(int unsigned n);
		for (int i = 0; i < n; i++)
			send_vertex(rand_coord(), rand_coord(), rand_coord(), i == n - 1);
	endtask

	task automatic test_extremes();
		write_side(SideReset);
		send_vertex(32'sh80000000, 32'sh7fffffff, 32'sh00010000, 1'b0);
		send_vertex(32'sh7fffffff, 32'sh80000000, 32'sh00010000, 1'b0);
		send_vertex(32'sh00000000, 32'sh00000001, 32'sh00010000, 1'b1);
		// A single vertex mesh: every axis is flat.
		send_vertex(32'sh12345678, 32'shedcba987, 32'sh0, 1'b1);
		drain_outputs();
		write_side('1);
		send_vertex(32'sh80000000, 32'sh80000000, 32'sh5, 1'b0);
		send_vertex(32'sh7fffffff, 32'sh7ffffffe, 32'sh5, 1'b0);
		send_vertex(32'sh3, 32'shffffffff, 32'sh6, 1'b1);
		drain_outputs();
		write_side('0);
		send_vertex(32'sh1, 32'sh2, 32'sh3, 1'b0);
		send_vertex(32'sh7fffffff, 32'sh80000000, 32'sh3, 1'b1);
		drain_outputs();
	endtask

	// Overfills the store: beats beyond the depth are dropped, the final one
	// included, and the pass still covers the stored vertices.
	task automatic test_overflow();
		write_side(31'd65536);
		for (int i = 0; i < Depth + 3; i++)
			send_vertex(rand_coord(), coord_t'(i), 32'sh0, i == Depth + 2);
		drain_outputs();
	endtask

	// Holds the receiver off while the sender keeps offering beats, so the
	// output side fills and the input stalls.
	task automatic test_backpressure();
		write_side(31'd1000000);
		fork
			begin
				hold_receiver = 1'b1;
				repeat (600) @(posedge clk);
				hold_receiver = 1'b0;
			end
			begin
				send_mesh(6);
				send_mesh(5);
			end
		join
		drain_outputs();
	endtask

	task automatic test_random(int unsigned sidle, int unsigned rstall, int unsigned beats);
		int unsigned sent;
		int unsigned n;
		send_idle_pct  = sidle;
		recv_stall_pct = rstall;
		write_side(31'($urandom));
		sent = 0;
		while (sent < beats) begin
			n = $urandom_range(6, 1);
			send_mesh(n);
			sent += n;
		end
		drain_outputs();
	endtask

	// Receiver: random stalls, or a long hold while requested.
	always @(posedge clk) begin
		out_ready <= !hold_receiver && ($urandom_range(99) >= recv_stall_pct);
	end

	// Checker of every output beat against the oldest expectation.
	always @(posedge clk) begin
		norm_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_norms.size() == 0) begin
				$display("%0t: output beat with nothing expected: %h %h %h", $time,
					norm_x, norm_y, norm_z);
				error_count++;
			end else begin
				want = pending_norms.pop_front();
				if (norm_x !== want.x) begin
					$display("%0t: norm_x expected %h actual %h", $time, want.x, norm_x);
					error_count++;
				end
				if (norm_y !== want.y) begin
					$display("%0t: norm_y expected %h actual %h", $time, want.y, norm_y);
					error_count++;
				end
				if (norm_z !== want.z) begin
					$display("%0t: norm_z expected %h actual %h", $time, want.z, norm_z);
					error_count++;
				end
				if (flat_axis !== want.flat) begin
					$display("%0t: flat_axis expected %b actual %b", $time, want.flat,
						flat_axis);
					error_count++;
				end
				if (end_of_run !== want.last) begin
					$display("%0t: end_of_run expected %b actual %b", $time, want.last,
						end_of_run);
					error_count++;
				end
			end
		end
	end

	// Watchdog: counts cycles with no beat on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchLimit) begin
			$display("bounding_box_vertex_normalizer_core regression: fail");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_overflow();
		test_backpressure();
		test_random(0, 0, 20);
		test_random(64, 0, 20);
		test_random(0, 64, 20);
		test_random(20, 20, 20);
		recv_stall_pct = 0;
		repeat (50) @(posedge clk);
		if (error_count == 0 && pending_norms.size() == 0)
			$display("bounding_box_vertex_normalizer_core regression: pass");
		else
			$display("bounding_box_vertex_normalizer_core regression: fail");
		$finish;
	end
endmodule

/* files.f */
+incdir+hdl
hdl/bbvn_pkg.sv
hdl/bbvn_front.sv
hdl/bbvn_fifo.sv
hdl/bbvn_back.sv
hdl/bounding_box_vertex_normalizer_core.sv
tb/sv/bounding_box_vertex_normalizer_core_test.sv
